// ----- sv/i2c_scl_pkg.sv -----
// Shared types and constants for the SCL divider search block.
// Used by i2c_scl_div and i2c_scl_divider_search; depends on nothing else.
package i2c_scl_pkg;

   // Number of divider steps tried, and the width of the step counter.
   localparam int STEP_COUNT = 64;
   localparam int STEP_W     = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;

   // Field widths.
   localparam int RATE_W   = 30;
   localparam int TARGET_W = 23;
   localparam int TIME_W   = 16;
   localparam int SUM_W    = 18;
   localparam int MHZ_W    = 11;
   localparam int PROD_W   = 28;
   localparam int RND_W    = 18;
   localparam int PRE_W    = 3;
   localparam int OSTEP_W  = 6;
   localparam int WORD_W   = 9;
   localparam int STAT_W   = 2;
   localparam int GEN_W    = 2;

   // Shared divider operand width and iteration counter width.
   localparam int DIV_W = 31;
   localparam int CNT_W = $clog2(DIV_W);

   // Defaults and scaling constants.
   localparam int unsigned DEFAULT_BUS_HZ   = 100000;
   localparam int unsigned DEFAULT_FALL_NS  = 35;
   localparam int unsigned DEFAULT_RISE_NS  = 200;
   localparam int unsigned DEFAULT_DELAY_NS = 50;
   localparam int unsigned PRESCALE_UNIT_HZ = 20000000;
   localparam int unsigned HALF_MHZ         = 500000;
   localparam int unsigned ONE_MHZ          = 1000000;
   localparam int unsigned HALF_KILO        = 500;
   localparam int unsigned ONE_KILO         = 1000;
   localparam int unsigned BASE_DIVIDER     = 20;

   // Result status codes.
   localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_CLK_HIGH = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_NO_STEP  = 2'd2;

   // Request to and response from the shared divider.
   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- sv/i2c_scl_div.sv -----
// Radix-2 restoring divider shared by every division of the search.
// Depends on i2c_scl_pkg for the operand width and the request types.
module i2c_scl_div (
   input  logic                     clock,
   input  logic                     reset,
   input  i2c_scl_pkg::div_req_type div_req,
   output i2c_scl_pkg::div_rsp_type div_rsp
);
   import i2c_scl_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [DIV_W:0]   rem_sh;
   logic [DIV_W:0]   diff;
   logic             ge;

   // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIV_W-1]};
      diff   = rem_sh - {1'b0, dvs_ff};
      ge     = (rem_sh >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   // A new division is only started once the previous one has finished.
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   // The last iteration is always followed by a completion pulse.
   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !div_req.start && cnt_ff == CNT_W'(DIV_W - 1)) |=> done_ff)
      else $error("divider missed its completion");

   // Completion is never signaled without a division in progress before it.
   a_done_from_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without work");

endmodule

// ----- sv/i2c_scl_divider_search.sv -----
// Top level of the SCL divider search: input checks, sequencer and result register.
// Depends on i2c_scl_pkg and the shared divider i2c_scl_div.
//
// One request item yields exactly one response item. A request whose clock is too
// high for the prescaler width skips the search and goes straight to the output state.
// Otherwise the sequencer runs every division on the one 31-bit radix-2 divider:
// three divisions for the internal clock and the rounded delay term, then one per
// divider step tried, up to 64. The block takes no new request while a search runs;
// a finished response waits in its output register while the next request is
// already accepted.
module i2c_scl_divider_search (
   input  logic         clock,
   input  logic         reset,
   // Configuration: generation code.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_data,
   // Request, tdata from bit 0: clock_rate_hz[29:0], target_bus_hz[52:30],
   // fall_time_ns[68:53], rise_time_ns[84:69], internal_delay_ns[100:85], zero pad.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,
   // Response, tdata from bit 0: prescale[2:0], divider_step[8:3],
   // clock_word[17:9], achieved_scl_hz[47:18].
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,
   // Response tuser: status[1:0].
   output logic [1:0]   rsp_tuser
);
   import i2c_scl_pkg::*;

   // Sequencer state codes.
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_ICK    = 4'd1;
   localparam logic [3:0] S_ICK_W  = 4'd2;
   localparam logic [3:0] S_MHZ    = 4'd3;
   localparam logic [3:0] S_MHZ_W  = 4'd4;
   localparam logic [3:0] S_MUL    = 4'd5;
   localparam logic [3:0] S_RND    = 4'd6;
   localparam logic [3:0] S_RND_W  = 4'd7;
   localparam logic [3:0] S_STEP   = 4'd8;
   localparam logic [3:0] S_STEP_W = 4'd9;
   localparam logic [3:0] S_OUT    = 4'd10;

   localparam logic [RATE_W-1:0] LIMIT_NARROW = RATE_W'(4 * PRESCALE_UNIT_HZ);
   localparam logic [RATE_W-1:0] LIMIT_WIDE   = RATE_W'(8 * PRESCALE_UNIT_HZ);

   logic [3:0]          state_ff, state_in;
   logic [GEN_W-1:0]    gen_ff, gen_in;
   logic                wide_ff, wide_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic [TARGET_W-1:0] target_ff, target_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [PRE_W-1:0]    pre_ff, pre_in;
   logic [RATE_W-1:0]   ick_ff, ick_in;
   logic [MHZ_W-1:0]    mhz_ff, mhz_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [RND_W-1:0]    rnd_ff, rnd_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [RATE_W-1:0]   scl_ff, scl_in;
   logic [STAT_W-1:0]   status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [47:0]         rsp_data_ff, rsp_data_in;
   logic [STAT_W-1:0]   rsp_user_ff, rsp_user_in;

   logic [RATE_W-1:0]   req_rate;
   logic [TARGET_W-1:0] req_target;
   logic [TIME_W-1:0]   req_fall, req_rise, req_dly;
   logic [PRE_W-1:0]    req_pre;
   logic                req_high;
   logic                req_take;
   logic                rsp_free;
   logic [WORD_W-1:0]   step9;
   logic [WORD_W-1:0]   word;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   i2c_scl_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Unpack the request and apply defaults for zero fields.
   always_comb begin
      req_rate   = req_tdata[29:0];
      req_target = req_tdata[52:30];
      req_fall   = req_tdata[68:53];
      req_rise   = req_tdata[84:69];
      req_dly    = req_tdata[100:85];
      if (req_target == '0) req_target = TARGET_W'(DEFAULT_BUS_HZ);
      if (req_fall == '0)   req_fall   = TIME_W'(DEFAULT_FALL_NS);
      if (req_rise == '0)   req_rise   = TIME_W'(DEFAULT_RISE_NS);
      if (req_dly == '0)    req_dly    = TIME_W'(DEFAULT_DELAY_NS);
   end

   // Prescaler: count the 20 MHz thresholds at or below the rate.
   always_comb begin
      req_pre = '0;
      for (int k = 1; k < 8; k++) begin
         req_pre = req_pre + PRE_W'(req_rate >= RATE_W'(k * PRESCALE_UNIT_HZ));
      end
      req_high = (gen_ff == '0) ? (req_rate >= LIMIT_NARROW) : (req_rate >= LIMIT_WIDE);
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // Divider operands follow the sequencer state.
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = DIV_W'(rate_ff);
      div_req.divisor  = DIV_W'(pre_ff) + DIV_W'(1);
      unique case (state_ff)
         S_ICK: begin
            div_req.start = 1'b1;
         end
         S_MHZ: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(ick_ff) + DIV_W'(HALF_MHZ);
            div_req.divisor  = DIV_W'(ONE_MHZ);
         end
         S_RND: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(prod_ff) + DIV_W'(HALF_KILO);
            div_req.divisor  = DIV_W'(ONE_KILO);
         end
         S_STEP: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(ick_ff);
            div_req.divisor  = DIV_W'(rnd_ff) + DIV_W'(BASE_DIVIDER)
                               + (DIV_W'(step_ff) << 3);
         end
         default: begin
         end
      endcase
   end

   // Clock word from the chosen step and the prescaler.
   always_comb begin
      step9 = WORD_W'(step_ff);
      word  = (wide_ff ? (step9 << 3) : (step9 << 2)) | WORD_W'(pre_ff);
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      gen_in       = gen_ff;
      wide_in      = wide_ff;
      rate_in      = rate_ff;
      target_in    = target_ff;
      sum_in       = sum_ff;
      pre_in       = pre_ff;
      ick_in       = ick_ff;
      mhz_in       = mhz_ff;
      prod_in      = prod_ff;
      rnd_in       = rnd_ff;
      step_in      = step_ff;
      scl_in       = scl_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      if (csr_valid && csr_ready) gen_in = csr_data;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               rate_in   = req_rate;
               target_in = req_target;
               sum_in    = SUM_W'(req_fall) + SUM_W'(req_rise) + SUM_W'(req_dly);
               pre_in    = req_pre;
               wide_in   = (gen_ff != '0);
               step_in   = '0;
               scl_in    = '0;
               if (req_high) begin
                  status_in = STATUS_CLK_HIGH;
                  state_in  = S_OUT;
               end else begin
                  status_in = STATUS_OK;
                  state_in  = S_ICK;
               end
            end
         end
         S_ICK:   state_in = S_ICK_W;
         S_ICK_W: begin
            if (div_rsp.done) begin
               ick_in   = div_rsp.quotient[RATE_W-1:0];
               state_in = S_MHZ;
            end
         end
         S_MHZ:   state_in = S_MHZ_W;
         S_MHZ_W: begin
            if (div_rsp.done) begin
               mhz_in   = div_rsp.quotient[MHZ_W-1:0];
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = PROD_W'(mhz_ff * sum_ff);
            state_in = S_RND;
         end
         S_RND:   state_in = S_RND_W;
         S_RND_W: begin
            if (div_rsp.done) begin
               rnd_in   = div_rsp.quotient[RND_W-1:0];
               state_in = S_STEP;
            end
         end
         S_STEP:  state_in = S_STEP_W;
         S_STEP_W: begin
            // Take the first step whose SCL frequency does not exceed the target.
            if (div_rsp.done) begin
               if (div_rsp.quotient <= DIV_W'(target_ff)) begin
                  scl_in   = div_rsp.quotient[RATE_W-1:0];
                  state_in = S_OUT;
               end else if (step_ff == STEP_W'(STEP_COUNT - 1)) begin
                  status_in = STATUS_NO_STEP;
                  state_in  = S_OUT;
               end else begin
                  step_in  = step_ff + 1'b1;
                  state_in = S_STEP;
               end
            end
         end
         S_OUT: begin
            // Load the response register once it is free.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = '0;
               if (status_ff != STATUS_CLK_HIGH) rsp_data_in[2:0] = pre_ff;
               if (status_ff == STATUS_OK) begin
                  rsp_data_in[8:3]   = OSTEP_W'(step_ff);
                  rsp_data_in[17:9]  = word;
                  rsp_data_in[47:18] = scl_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      wide_ff     <= wide_in;
      rate_ff     <= rate_in;
      target_ff   <= target_in;
      sum_ff      <= sum_in;
      pre_ff      <= pre_in;
      ick_ff      <= ick_in;
      mhz_ff      <= mhz_in;
      prod_ff     <= prod_in;
      rnd_ff      <= rnd_in;
      step_ff     <= step_in;
      scl_ff      <= scl_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // The divider only reports completion while the sequencer waits for it.
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_ICK_W || state_ff == S_MHZ_W ||
                        state_ff == S_RND_W || state_ff == S_STEP_W))
      else $error("divider result arrived outside a wait state");

   // A taken request closes the input until its response is built.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_tready)
      else $error("request accepted while a search runs");

   // Failed searches report no step, word or frequency.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff != STATUS_OK) |-> (rsp_data_ff[47:3] == '0))
      else $error("failed response carries a step");

   // A response only ever carries one of the three defined status codes.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_user_ff == STATUS_OK || rsp_user_ff == STATUS_CLK_HIGH ||
                        rsp_user_ff == STATUS_NO_STEP))
      else $error("undefined response status");

endmodule

// ----- bench/i2c_scl_divider_search_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for i2c_scl_divider_search: a directed vector list, then random
// requests under several idling mixes, each response checked against a typed answer or
// a local predictor. Depends on i2c_scl_pkg and the i2c_scl_divider_search top level.
module i2c_scl_divider_search_test;
   import i2c_scl_pkg::*;

   // Generation codes written to the configuration channel.
   localparam logic [GEN_W-1:0] GEN_OLD      = 2'd0;
   localparam logic [GEN_W-1:0] GEN_MID      = 2'd1;
   localparam logic [GEN_W-1:0] GEN_NEW      = 2'd2;
   localparam logic [GEN_W-1:0] GEN_RESERVED = 2'd3;

   localparam int unsigned CYCLE_LIMIT    = 4_000_000;
   localparam int          ITEMS_PER_MIX  = 65;
   localparam int          MAX_REPORTS    = 10;

   // One response item, as the predictor and the checker see it.
   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [PRE_W-1:0]   prescale;
      logic [OSTEP_W-1:0] step;
      logic [WORD_W-1:0]  word;
      logic [RATE_W-1:0]  scl_hz;
   } scl_result_type;

   // One directed vector: the generation it runs under and an optional typed answer.
   typedef struct {
      logic [GEN_W-1:0] gen;
      logic [103:0]     data;
      bit               exact;
      scl_result_type   result;
   } directed_vector_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   logic [GEN_W-1:0]      csr_data    = GEN_OLD;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [103:0]          req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [47:0]           rsp_tdata;
   logic [1:0]            rsp_tuser;

   logic [GEN_W-1:0]      generation  = GEN_OLD;
   int                    sender_idle_pct    = 0;
   int                    receiver_stall_pct = 0;
   int unsigned           cycle_count = 0;
   int                    error_count = 0;
   scl_result_type        pending_results[$];
   directed_vector_type   directed_vectors[$];

   i2c_scl_divider_search dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Works out the prescaler, divider step, clock word and SCL rate for one request.
   function automatic scl_result_type predict_divider(input logic [103:0] d,
                                                      input logic [GEN_W-1:0] gen);
      logic [63:0]    rate, target, fall, rise, dly;
      logic [63:0]    pre, ick, sum, rnd, scl, chosen;
      int             width;
      bit             found;
      scl_result_type r;
      r      = '0;
      scl    = '0;
      chosen = '0;
      found  = 1'b0;
      rate   = 64'(d[29:0]);
      target = 64'(d[52:30]);
      fall   = 64'(d[68:53]);
      rise   = 64'(d[84:69]);
      dly    = 64'(d[100:85]);
      // A zero field takes its default.
      if (target == 0) target = DEFAULT_BUS_HZ;
      if (fall == 0) fall = DEFAULT_FALL_NS;
      if (rise == 0) rise = DEFAULT_RISE_NS;
      if (dly == 0) dly = DEFAULT_DELAY_NS;
      // Only the oldest generation has the narrow prescaler.
      width = (gen == GEN_OLD) ? 2 : 3;
      pre = rate / PRESCALE_UNIT_HZ;
      if (pre >= (64'd1 << width)) begin
         r.status = STATUS_CLK_HIGH;
      end else begin
         ick = rate / (pre + 1);
         sum = fall + rise + dly;
         rnd = (((ick + HALF_MHZ) / ONE_MHZ) * sum + HALF_KILO) / ONE_KILO;
         // Walk the steps until the SCL rate drops to the target.
         for (int s = 0; s < STEP_COUNT && !found; s++) begin
            scl = ick / (64'(BASE_DIVIDER) + 64'(8 * s) + rnd);
            if (scl <= target) begin
               found  = 1'b1;
               chosen = 64'(s);
            end
         end
         r.prescale = pre[2:0];
         if (!found) begin
            r.status = STATUS_NO_STEP;
         end else begin
            r.status = STATUS_OK;
            r.step   = chosen[5:0];
            r.word   = 9'((chosen << width) | pre);
            r.scl_hz = scl[29:0];
         end
      end
      return r;
   endfunction

   function automatic logic [103:0] pack_request(input logic [29:0] rate,
                                                 input logic [22:0] target,
                                                 input logic [15:0] fall,
                                                 input logic [15:0] rise,
                                                 input logic [15:0] dly);
      return {3'b000, dly, rise, fall, target, rate};
   endfunction

   task automatic add_vector(input logic [GEN_W-1:0] gen, input logic [29:0] rate,
                             input logic [22:0] target, input logic [15:0] fall,
                             input logic [15:0] rise, input logic [15:0] dly,
                             input bit exact, input logic [STAT_W-1:0] status,
                             input logic [PRE_W-1:0] prescale);
      directed_vector_type v;
      v.gen             = gen;
      v.data            = pack_request(rate, target, fall, rise, dly);
      v.exact           = exact;
      v.result          = '0;
      v.result.status   = status;
      v.result.prescale = prescale;
      directed_vectors.push_back(v);
   endtask

   // Timing field: mostly zero or a realistic value, sometimes anything 16 bits hold.
   function automatic logic [15:0] random_time();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(3))
         0:       return 16'd0;
         3:       return r[15:0];
         default: return 16'($urandom_range(1, 1000));
      endcase
   endfunction

   // Most requests take a rate up to 170 MHz; a tenth take any bit pattern.
   function automatic logic [103:0] random_request();
      logic [31:0] r0, r1;
      logic [29:0] rate;
      logic [22:0] target;
      r0 = $urandom();
      r1 = $urandom();
      if ($urandom_range(99) < 10) begin
         rate   = r0[29:0];
         target = r1[22:0];
      end else begin
         rate = 30'($urandom_range(170_000_000));
         case ($urandom_range(3))
            0:       target = 23'd0;
            1:       target = 23'($urandom_range(1, 60_000));
            2:       target = 23'($urandom_range(60_000, 1_000_000));
            default: target = r1[22:0];
         endcase
      end
      return pack_request(rate, target, random_time(), random_time(), random_time());
   endfunction

   // Presents one request item, records what it should produce, then maybe idles.
   task automatic push_request(input logic [103:0] d, input bit exact,
                               input scl_result_type typed);
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(exact ? typed : predict_divider(d, generation));
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
   endtask

   // Changes the generation once the block has answered everything it took.
   task automatic write_generation(input logic [GEN_W-1:0] gen);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= gen;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      generation  = gen;
   endtask

   // Response side: random stalls at the rate the current mix asks for.
   always @(posedge clock) begin
      rsp_tready <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);
   end

   // Compares each response item with the oldest outstanding prediction.
   always @(posedge clock) begin
      scl_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status   = rsp_tuser;
         got.prescale = rsp_tdata[2:0];
         got.step     = rsp_tdata[8:3];
         got.word     = rsp_tdata[17:9];
         got.scl_hz   = rsp_tdata[47:18];
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("cycle %0d: response with none outstanding, status %0d scl %0d",
                        cycle_count, got.status, got.scl_hz);
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.prescale !== want.prescale ||
                got.step !== want.step || got.word !== want.word ||
                got.scl_hz !== want.scl_hz) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display({"cycle %0d: expected status %0d prescale %0d step %0d ",
                            "word %0h scl %0d, got status %0d prescale %0d step %0d ",
                            "word %0h scl %0d"}, cycle_count,
                           want.status, want.prescale, want.step, want.word, want.scl_hz,
                           got.status, got.prescale, got.step, got.word, got.scl_hz);
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      logic [GEN_W-1:0] mix_gen[4];
      int               mix_send[4];
      int               mix_stall[4];
      mix_gen   = '{GEN_OLD, GEN_RESERVED, GEN_MID, GEN_NEW};
      mix_send  = '{0, 82, 0, 27};
      mix_stall = '{0, 0, 82, 27};

      // Zero clock, defaults, prescaler edges for the narrow width.
      add_vector(GEN_OLD, 30'd0, 23'd0, 16'd0, 16'd0, 16'd0, 1, STATUS_OK, 3'd0);
      add_vector(GEN_OLD, 30'h3FFF_FFFF, 23'd0, 16'd0, 16'd0, 16'd0, 1, STATUS_CLK_HIGH, 3'd0);
      add_vector(GEN_OLD, 30'd80_000_000, 23'd0, 16'd0, 16'd0, 16'd0, 1, STATUS_CLK_HIGH, 3'd0);
      add_vector(GEN_OLD, 30'd79_999_999, 23'd0, 16'd0, 16'd0, 16'd0, 0, STATUS_OK, 3'd0);
      add_vector(GEN_OLD, 30'd20_000_000, 23'd0, 16'd0, 16'd0, 16'd0, 0, STATUS_OK, 3'd0);
      add_vector(GEN_OLD, 30'd19_999_999, 23'h7F_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 0, STATUS_OK, 3'd0);
      add_vector(GEN_OLD, 30'd66_000_000, 23'd1, 16'd0, 16'd0, 16'd0, 1, STATUS_NO_STEP, 3'd3);
      add_vector(GEN_OLD, 30'd50_000_000, 23'd5_000_000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 0, STATUS_OK, 3'd0);
      add_vector(GEN_OLD, 30'd40_000_000, 23'd400_000, 16'd1, 16'd1, 16'd1, 0, STATUS_OK, 3'd0);
      // The undefined generation code behaves like the wide ones.
      add_vector(GEN_RESERVED, 30'd80_000_000, 23'd0, 16'd0, 16'd0, 16'd0, 0, STATUS_OK, 3'd0);
      add_vector(GEN_RESERVED, 30'd159_999_999, 23'd0, 16'd0, 16'd0, 16'd0, 0, STATUS_OK, 3'd0);
      add_vector(GEN_RESERVED, 30'd160_000_000, 23'd0, 16'd0, 16'd0, 16'd0,
                 1, STATUS_CLK_HIGH, 3'd0);
      add_vector(GEN_RESERVED, 30'd1_000_000_000, 23'd0, 16'd0, 16'd0, 16'd0,
                 1, STATUS_CLK_HIGH, 3'd0);
      add_vector(GEN_MID, 30'd100_000_000, 23'd0, 16'd0, 16'd0, 16'd0, 0, STATUS_OK, 3'd0);
      add_vector(GEN_MID, 30'd160_000_000, 23'd0, 16'd0, 16'd0, 16'd0, 1, STATUS_CLK_HIGH, 3'd0);
      add_vector(GEN_MID, 30'd120_000_000, 23'd1, 16'd0, 16'd0, 16'd0, 1, STATUS_NO_STEP, 3'd6);
      add_vector(GEN_NEW, 30'd140_000_000, 23'd1_000_000, 16'd0, 16'd0, 16'd0, 0, STATUS_OK, 3'd0);
      add_vector(GEN_NEW, 30'h3FFF_FFFF, 23'd0, 16'd0, 16'd0, 16'd0, 1, STATUS_CLK_HIGH, 3'd0);
      add_vector(GEN_NEW, 30'd33_000_000, 23'd100_000, 16'd300, 16'd1000, 16'd0,
                 0, STATUS_OK, 3'd0);
      add_vector(GEN_OLD, 30'd24_000_000, 23'd400_000, 16'd0, 16'd0, 16'd0, 0, STATUS_OK, 3'd0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed vectors with no idling on either side.
      foreach (directed_vectors[i]) begin
         if (directed_vectors[i].gen != generation)
            write_generation(directed_vectors[i].gen);
         push_request(directed_vectors[i].data, directed_vectors[i].exact,
                      directed_vectors[i].result);
      end

      // Random requests, one generation and one idling mix per pass.
      for (int m = 0; m < 4; m++) begin
         write_generation(mix_gen[m]);
         sender_idle_pct    = mix_send[m];
         receiver_stall_pct = mix_stall[m];
         for (int n = 0; n < ITEMS_PER_MIX; n++)
            push_request(random_request(), 1'b0, '0);
      end

      // Drain, then allow time for any stray response item to show up.
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
